/* rtl/core/rtpft_pkg.sv */
// ----------------------------------------------------------------------------
// rtpft_pkg : shared types and constants of the rtp flow table
// word layouts, result kinds, controller states and datapath commands
// ----------------------------------------------------------------------------
package rtpft_pkg;

    localparam int unsigned TableEntriesDefault = 32;
    localparam logic [31:0] IdleTimeoutReset    = 32'd30;
    localparam logic [31:0] SweepPeriodReset    = 32'd5;

    localparam int unsigned SlotW = 5;
    localparam int unsigned KindW = 3;

    // result kinds
    localparam logic [KindW-1:0] KIND_RECORDED = 3'd0;
    localparam logic [KindW-1:0] KIND_ZERO_SSRC = 3'd1;
    localparam logic [KindW-1:0] KIND_FULL     = 3'd2;
    localparam logic [KindW-1:0] KIND_CLOSED   = 3'd3;
    localparam logic [KindW-1:0] KIND_TICK     = 3'd4;

    // configuration register indexes
    localparam logic CFG_IDLE_TIMEOUT = 1'b0;
    localparam logic CFG_SWEEP_PERIOD = 1'b1;

    localparam logic ACT_PACKET = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] pkt_ssrc;
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic [31:0] dst_addr;
        logic [15:0] dst_port;
        logic [15:0] seq_in;
        logic [7:0]  pt_in;
        logic [31:0] rtp_ts_in;
        logic [31:0] now;
    } in_word_t;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [SlotW-1:0] slot;
        logic             new_stream;
        logic [31:0]      out_ssrc;
        logic [31:0]      rec_timestamp;
        logic [15:0]      rec_seq;
        logic [7:0]       rec_pt;
        logic [31:0]      frame_total;
        logic [31:0]      duration;
        logic             last;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    // command bundle from controller to datapath
    typedef struct packed {
        logic load;       // capture input word, start at slot 0
        logic scan;       // read current slot, advance
        logic write_pkt;  // write packet update to target slot
        logic evict;      // clear valid of evicted slot
        logic set_sweep;  // last sweep time := now
        logic emit;       // load output register from result
        logic [KindW-1:0] kind;
        logic             is_last;
    } cmd_t;

    // status bundle from datapath to controller
    typedef struct packed {
        logic scan_done;   // all slots read and checked
        logic hit;         // key found
        logic have_free;   // a free slot exists
        logic zero_ssrc;
        logic is_tick;
        logic sweep_due;
        logic expire;      // current sweep slot qualifies for eviction
        logic out_busy;    // output register holds a stalled word
    } stat_t;

endpackage

/* rtl/core/rtpft_datapath.sv */
// ----------------------------------------------------------------------------
// rtpft_datapath : flow table memories, slot walker and output register
// one slot read a cycle while a scan is commanded, registered read data, compare in the next cycle
// ----------------------------------------------------------------------------
module rtpft_datapath #(
    parameter int unsigned TABLE_ENTRIES = rtpft_pkg::TableEntriesDefault
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rtpft_pkg::in_word_t  in_word,
    input  logic [31:0]          idle_timeout,
    input  logic [31:0]          sweep_period,
    input  rtpft_pkg::cmd_t      cmd,
    output rtpft_pkg::stat_t     stat,
    output rtpft_pkg::out_word_t out_word,
    output logic                 out_valid,
    input  logic                 out_stall
);
    import rtpft_pkg::*;

    localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

    // memories
    logic [31:0] mem_ssrc    [TABLE_ENTRIES];
    logic [47:0] mem_src     [TABLE_ENTRIES];
    logic [47:0] mem_dst     [TABLE_ENTRIES];
    logic [31:0] mem_created [TABLE_ENTRIES];
    logic [31:0] mem_updated [TABLE_ENTRIES];
    logic [31:0] mem_frames  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;

    in_word_t    cur_reg;
    logic [31:0] last_sweep_reg;
    logic [CntW-1:0] addr_reg;      // read address, counts to depth
    logic [CntW-1:0] rd_slot_reg;   // slot of registered read data
    logic        rd_ok_reg;         // registered data present
    logic [31:0] rd_ssrc_reg, rd_created_reg, rd_updated_reg, rd_frames_reg;
    logic [47:0] rd_src_reg, rd_dst_reg;
    logic        rd_valid_reg;
    logic        hit_reg, free_reg;
    logic [IdxW-1:0] hit_idx_reg, free_idx_reg;
    logic        pend_reg;
    logic        out_valid_reg;
    out_word_t   out_reg;

    logic [IdxW-1:0] rd_idx, addr_idx, tgt_idx;
    logic        key_match, expire_now;
    logic        scanning_done;
    out_word_t   res;

    assign addr_idx = addr_reg[IdxW-1:0];
    assign rd_idx   = rd_slot_reg[IdxW-1:0];
    assign tgt_idx  = hit_reg ? hit_idx_reg : free_idx_reg;

    assign key_match = rd_valid_reg && (rd_ssrc_reg == cur_reg.pkt_ssrc)
        && (rd_src_reg == {cur_reg.src_addr, cur_reg.src_port})
        && (rd_dst_reg == {cur_reg.dst_addr, cur_reg.dst_port});
    assign expire_now = rd_valid_reg && ((cur_reg.now - rd_updated_reg) >= idle_timeout);
    assign scanning_done = (addr_reg == CntW'(TABLE_ENTRIES)) && !rd_ok_reg;

    // memory writes and reads
    always_ff @(posedge clk)
    begin
        if (cmd.write_pkt)
        begin
            if (!hit_reg)
            begin
                mem_ssrc[tgt_idx]    <= cur_reg.pkt_ssrc;
                mem_src[tgt_idx]     <= {cur_reg.src_addr, cur_reg.src_port};
                mem_dst[tgt_idx]     <= {cur_reg.dst_addr, cur_reg.dst_port};
                mem_created[tgt_idx] <= cur_reg.now;
                mem_frames[tgt_idx]  <= 32'd1;
            end
            else
            begin
                mem_frames[tgt_idx] <= rd_frames_reg + 32'd1;
            end
            mem_updated[tgt_idx] <= cur_reg.now;
        end
        if (cmd.scan && addr_reg < CntW'(TABLE_ENTRIES))
        begin
            rd_ssrc_reg    <= mem_ssrc[addr_idx];
            rd_src_reg     <= mem_src[addr_idx];
            rd_dst_reg     <= mem_dst[addr_idx];
            rd_created_reg <= mem_created[addr_idx];
            rd_updated_reg <= mem_updated[addr_idx];
            rd_frames_reg  <= mem_frames[addr_idx];
        end
        else if (cmd.load)
        begin
            rd_frames_reg <= rd_frames_reg;
        end
        // hit frame count fetched by re-reading target before update
        if (pend_reg)
            rd_frames_reg <= mem_frames[tgt_idx];
        if (cmd.load)
            cur_reg <= in_word;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            last_sweep_reg <= '0;
            addr_reg       <= '0;
            rd_slot_reg    <= '0;
            rd_ok_reg      <= 1'b0;
            rd_valid_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            hit_idx_reg    <= '0;
            free_idx_reg   <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                addr_reg  <= '0;
                rd_ok_reg <= 1'b0;
                hit_reg   <= 1'b0;
                free_reg  <= 1'b0;
            end
            else if (cmd.scan)
            begin
                if (addr_reg < CntW'(TABLE_ENTRIES))
                begin
                    rd_ok_reg    <= 1'b1;
                    rd_slot_reg  <= addr_reg;
                    rd_valid_reg <= valid_reg[addr_idx];
                    addr_reg     <= addr_reg + 1'b1;
                end
                else
                begin
                    rd_ok_reg <= 1'b0;
                end
                if (rd_ok_reg && !cur_reg.action)
                begin
                    if (key_match && !hit_reg)
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= rd_idx;
                    end
                    if (!rd_valid_reg && !free_reg)
                    begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= rd_idx;
                    end
                end
            end
            pend_reg <= cmd.scan && !cur_reg.action && scanning_done && hit_reg;
            if (cmd.write_pkt)
                valid_reg[tgt_idx] <= 1'b1;
            if (cmd.evict)
                valid_reg[rd_idx] <= 1'b0;
            if (cmd.set_sweep)
                last_sweep_reg <= cur_reg.now;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // result word
    always_comb
    begin
        res = '0;
        res.kind = cmd.kind;
        res.last = cmd.is_last;
        unique case (cmd.kind)
            KIND_RECORDED:
            begin
                res.slot          = SlotW'(tgt_idx);
                res.new_stream    = !hit_reg;
                res.rec_timestamp = cur_reg.rtp_ts_in;
                res.rec_seq       = cur_reg.seq_in;
                res.rec_pt        = cur_reg.pt_in;
            end
            KIND_CLOSED:
            begin
                res.slot        = SlotW'(rd_idx);
                res.out_ssrc    = rd_ssrc_reg;
                res.frame_total = rd_frames_reg;
                res.duration    = rd_updated_reg - rd_created_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            out_reg <= res;
    end

    assign out_word  = out_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        stat.scan_done = scanning_done;
        stat.hit       = hit_reg;
        stat.have_free = free_reg;
        stat.zero_ssrc = (cur_reg.pkt_ssrc == 32'd0);
        stat.is_tick   = cur_reg.action;
        stat.sweep_due = !(sweep_period > (cur_reg.now - last_sweep_reg));
        stat.expire    = rd_ok_reg && expire_now;
        stat.out_busy  = out_valid_reg && out_stall;
    end

    a_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.write_pkt && cmd.evict))
        else $error("packet write and eviction together");
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid_reg && out_stall))
        else $error("output word overwritten");
    a_write_target: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_pkt |-> (hit_reg || free_reg))
        else $error("write with no target slot");
endmodule

/* rtl/core/rtpft_ctrl.sv */
// ----------------------------------------------------------------------------
// rtpft_ctrl : sequencer of the flow table
// walks the slots when needed; records or rejects packets, evicts on a due tick, closes the tick
// ----------------------------------------------------------------------------
module rtpft_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  rtpft_pkg::stat_t  stat,
    output rtpft_pkg::cmd_t   cmd
);
    import rtpft_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                // early exits before any walk
                if (stat.is_tick && !stat.sweep_due)
                begin
                    cmd.kind = KIND_TICK;
                    cmd.is_last = 1'b1;
                    if (!stat.out_busy)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (!stat.is_tick && stat.zero_ssrc)
                begin
                    cmd.kind = KIND_ZERO_SSRC;
                    cmd.is_last = 1'b1;
                    if (!stat.out_busy)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.set_sweep = stat.is_tick;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.is_tick && stat.expire)
                begin
                    // hold the walk until the closed word can leave
                    cmd.kind = KIND_CLOSED;
                    if (!stat.out_busy)
                    begin
                        cmd.emit  = 1'b1;
                        cmd.evict = 1'b1;
                        cmd.scan  = 1'b1;
                    end
                end
                else if (stat.scan_done)
                begin
                    if (stat.is_tick)
                        state_next = ST_EMIT;
                    else
                    begin
                        cmd.scan   = 1'b1;
                        state_next = ST_UPDATE;
                    end
                end
                else
                    cmd.scan = 1'b1;
            end
            ST_UPDATE:
            begin
                // this spare state lets a hit's frame count be re-read
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.is_last = 1'b1;
                if (stat.is_tick)
                    cmd.kind = KIND_TICK;
                else if (stat.hit || stat.have_free)
                    cmd.kind = KIND_RECORDED;
                else
                    cmd.kind = KIND_FULL;
                if (!stat.out_busy)
                begin
                    cmd.emit      = 1'b1;
                    cmd.write_pkt = !stat.is_tick && (stat.hit || stat.have_free);
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> state_reg == ST_IDLE)
        else $error("input taken while busy");
    a_load_next: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_DECIDE)
        else $error("load not followed by decision");
    a_evict_tick: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.evict |-> stat.is_tick)
        else $error("eviction outside a tick");
endmodule

/* rtl/core/rtp_flow_table_with_aging.sv */
// ----------------------------------------------------------------------------
// rtp_flow_table_with_aging : rtp stream table with idle aging
// keyed stream lookup and insert per packet, periodic eviction sweep per tick
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | word
//  in       | input     | in_valid/in_stall   | in_word_t (packet or tick)
//  out      | output    | out_valid/out_stall | out_word_t (one or more)
//  cfg      | input     | cfg_we              | idle_timeout, sweep_period
//
// a packet passes the decision state, the slot walk, the re-read state and
// the emit state before the next word is accepted; one slot of the table
// memories is read per cycle and compared in the next
// a due tick walks the slots too; a closed word leaves in the same cycle as
// the walk step and holds the walk only if the output stalls
// a tick that is not due or a zero ssrc packet is answered from the decision state
// reset clears the valid bits and last sweep time and restores config
// defaults; no clearing pass
// a stalled output holds the walk, the input is taken only between items
// ----------------------------------------------------------------------------
module rtp_flow_table_with_aging #(
    parameter int unsigned TABLE_ENTRIES = rtpft_pkg::TableEntriesDefault
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // input words
    input  logic                 in_valid,
    output logic                 in_stall,
    input  rtpft_pkg::in_word_t  in_word,
    // result words
    output logic                 out_valid,
    input  logic                 out_stall,
    output rtpft_pkg::out_word_t out_word,
    // configuration writes
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data
);
    import rtpft_pkg::*;

    logic [31:0] idle_timeout_reg;
    logic [31:0] sweep_period_reg;
    cmd_t        cmd;
    stat_t       stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_timeout_reg <= IdleTimeoutReset;
            sweep_period_reg <= SweepPeriodReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_data;
                CFG_SWEEP_PERIOD: sweep_period_reg <= cfg_data;
                default:          idle_timeout_reg <= idle_timeout_reg;
            endcase
        end
    end

    // sequencer
    rtpft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table and result path
    rtpft_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_word      (in_word),
        .idle_timeout (idle_timeout_reg),
        .sweep_period (sweep_period_reg),
        .cmd          (cmd),
        .stat         (stat),
        .out_word     (out_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall)
    );

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("stalled result word changed");
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("input valid dropped while stalled");
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word taken at once");
endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench : self-checking bench of the rtp flow table with idle aging
// drives packet and tick words with bursty gaps, stalls the result side,
// predicts every result word from its own table model and compares in order
// ----------------------------------------------------------------------------
module testbench;
    import rtpft_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_word_t    in_word;
    logic        out_valid;
    logic        out_stall;
    out_word_t   out_word;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    rtp_flow_table_with_aging i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state: a copy of the stream table
    logic [31:0] idle_limit;
    logic [31:0] sweep_gap;
    logic        tbl_valid   [32];
    logic [31:0] tbl_ssrc    [32];
    logic [47:0] tbl_src     [32];
    logic [47:0] tbl_dst     [32];
    logic [31:0] tbl_created [32];
    logic [31:0] tbl_updated [32];
    logic [31:0] tbl_frames  [32];
    logic [31:0] last_sweep;

    out_word_t pending_words[$];
    int        errors;
    bit        stall_mode;
    logic [31:0] clock_s;   // running capture time for the random part

    // key pool so that random packets hit existing streams often
    logic [31:0] key_ssrc[8];
    logic [31:0] key_saddr[8];
    logic [15:0] key_sport[8];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // generous fixed limit
    initial
    begin
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end

    // table model: works out the result words of one accepted word
    task automatic predict_results(input in_word_t w);
        out_word_t r;
        int        hit;
        int        free_idx;
        logic [47:0] s;
        logic [47:0] d;
        begin
            hit = -1;
            free_idx = -1;
            s = {w.src_addr, w.src_port};
            d = {w.dst_addr, w.dst_port};
            r = '0;
            if (w.action == ACT_PACKET)
            begin
                r.last = 1'b1;
                if (w.pkt_ssrc == 32'd0)
                begin
                    r.kind = KIND_ZERO_SSRC;
                end
                else
                begin
                    for (int i = 0; i < 32; i++)
                    begin
                        if (tbl_valid[i])
                        begin
                            if (hit < 0 && tbl_ssrc[i] == w.pkt_ssrc && tbl_src[i] == s
                                && tbl_dst[i] == d)
                                hit = i;
                        end
                        else if (free_idx < 0)
                            free_idx = i;
                    end
                    if (hit < 0 && free_idx < 0)
                        r.kind = KIND_FULL;
                    else
                    begin
                        if (hit < 0)
                        begin
                            hit = free_idx;
                            tbl_valid[hit]   = 1'b1;
                            tbl_ssrc[hit]    = w.pkt_ssrc;
                            tbl_src[hit]     = s;
                            tbl_dst[hit]     = d;
                            tbl_created[hit] = w.now;
                            tbl_frames[hit]  = '0;
                            r.new_stream     = 1'b1;
                        end
                        tbl_updated[hit] = w.now;
                        tbl_frames[hit]  = tbl_frames[hit] + 32'd1;
                        r.kind          = KIND_RECORDED;
                        r.slot          = hit[4:0];
                        r.rec_timestamp = w.rtp_ts_in;
                        r.rec_seq       = w.seq_in;
                        r.rec_pt        = w.pt_in;
                    end
                end
                pending_words.push_back(r);
            end
            else
            begin
                // sweep only once the period has run out, differences wrap
                if (!(sweep_gap > (w.now - last_sweep)))
                begin
                    last_sweep = w.now;
                    for (int i = 0; i < 32; i++)
                    begin
                        if (tbl_valid[i] && (w.now - tbl_updated[i]) >= idle_limit)
                        begin
                            r = '0;
                            r.kind        = KIND_CLOSED;
                            r.slot        = i[4:0];
                            r.out_ssrc    = tbl_ssrc[i];
                            r.frame_total = tbl_frames[i];
                            r.duration    = tbl_updated[i] - tbl_created[i];
                            tbl_valid[i]  = 1'b0;
                            pending_words.push_back(r);
                        end
                    end
                end
                r = '0;
                r.kind = KIND_TICK;
                r.last = 1'b1;
                pending_words.push_back(r);
            end
        end
    endtask

    // hands one word to the block and records its expected results
    task automatic send_word(input in_word_t w);
        begin
            in_valid <= 1'b1;
            in_word  <= w;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            predict_results(w);
            in_valid <= 1'b0;
            // the block is busy for at least this cycle anyway
            @(posedge clk);
        end
    endtask

    // random gap between bursts, none most of the time
    task automatic sender_gap();
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        begin
            while (pending_words.size() != 0)
                @(posedge clk);
            // ticks that are not due may still be at work
            repeat (60) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
            cfg_we    <= 1'b0;
            if (idx == CFG_IDLE_TIMEOUT)
                idle_limit = val;
            else
                sweep_gap = val;
        end
    endtask

    function automatic in_word_t make_packet(input logic [31:0] ssrc, input logic [31:0] sa,
                                             input logic [15:0] sp, input logic [31:0] t);
        in_word_t w;
        begin
            w = '0;
            w.action    = ACT_PACKET;
            w.pkt_ssrc  = ssrc;
            w.src_addr  = sa;
            w.src_port  = sp;
            w.dst_addr  = 32'h0a00_0001;
            w.dst_port  = 16'd5004;
            w.seq_in    = 16'($urandom);
            w.pt_in     = 8'($urandom);
            w.rtp_ts_in = $urandom;
            w.now       = t;
            return w;
        end
    endfunction

    function automatic in_word_t make_tick(input logic [31:0] t);
        in_word_t w;
        begin
            w = '0;
            w.action = ACT_TICK;
            w.now    = t;
            return w;
        end
    endfunction

    // result side: stall pattern and in-order compare
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_words.size() == 0)
                begin
                    $display("%0t unexpected word %h", $time, out_word);
                    errors++;
                end
                else
                begin
                    if (out_word !== pending_words[0])
                    begin
                        $display("%0t mismatch expected %h actual %h", $time,
                                 pending_words[0], out_word);
                        errors++;
                    end
                    void'(pending_words.pop_front());
                end
            end
            if (stall_mode)
                out_stall <= ($urandom_range(0, 2) == 0);
            else
                out_stall <= 1'b0;
        end
    end

    // flip between stalling and free-running stretches
    always @(posedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            stall_mode <= ~stall_mode;
    end

    // extremes of every field, zero ssrc, refresh of an existing stream
    task automatic test_directed();
        in_word_t w;
        begin
            w = '1;
            w.action = ACT_PACKET;
            w.now = 32'd1;
            send_word(w);
            w = '0;
            w.action = ACT_PACKET;
            send_word(w);                       // zero ssrc
            w.pkt_ssrc = 32'd1;
            send_word(w);                       // zero addresses and ports, new stream
            send_word(w);                       // same key again
            w = '1;
            w.action = ACT_PACKET;
            w.now = 32'd3;
            send_word(w);                       // refresh the all-ones stream
            send_word(make_tick(32'd2));        // not due yet
            send_word(make_tick(32'd40));       // due, both idle long enough
            send_word(make_tick(32'hffff_ffff));
        end
    endtask

    // fill all 32 slots, hit the full table, then age everything out
    task automatic test_full_table();
        begin
            for (int i = 0; i < 33; i++)
                send_word(make_packet(32'h100 + i, 32'hc0a8_0000 + i, 16'd4000, 32'd100));
            send_word(make_packet(32'h100, 32'hc0a8_0000, 16'd4000, 32'd120));
            // pause until everything has drained
            wait_drained();
            send_word(make_tick(32'd200));
        end
    endtask

    // random packets on a small key pool mixed with advancing ticks and fully random words
    task automatic test_random(input int count);
        int k;
        in_word_t w;
        logic [287:0] rnd;
        begin
            for (int n = 0; n < count; n++)
            begin
                sender_gap();
                k = $urandom_range(0, 7);
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        clock_s = clock_s + $urandom_range(0, 20);
                        send_word(make_tick(clock_s));
                    end
                    2:
                    begin
                        rnd = {$urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom};
                        w = rnd[$bits(in_word_t)-1:0];
                        if ($urandom_range(0, 3) == 0)
                            w.pkt_ssrc = '0;
                        send_word(w);
                    end
                    default:
                    begin
                        clock_s = clock_s + $urandom_range(0, 3);
                        send_word(make_packet(key_ssrc[k], key_saddr[k], key_sport[k],
                                              clock_s));
                    end
                endcase
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_word    = '0;
        out_stall  = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_IDLE_TIMEOUT;
        cfg_data   = '0;
        stall_mode = 1'b0;
        errors     = 0;
        idle_limit = IdleTimeoutReset;
        sweep_gap  = SweepPeriodReset;
        last_sweep = '0;
        clock_s    = 32'd1000;
        for (int i = 0; i < 32; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_ssrc[i] = '0; tbl_src[i] = '0; tbl_dst[i] = '0;
            tbl_created[i] = '0; tbl_updated[i] = '0; tbl_frames[i] = '0;
        end
        for (int i = 0; i < 8; i++)
        begin
            key_ssrc[i]  = $urandom_range(1, 5000);
            key_saddr[i] = $urandom;
            key_sport[i] = 16'($urandom);
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_table();
        wait_drained();

        // extremes of both registers
        write_reg(CFG_IDLE_TIMEOUT, 32'd0);
        write_reg(CFG_SWEEP_PERIOD, 32'd0);
        test_random(40);
        wait_drained();
        write_reg(CFG_IDLE_TIMEOUT, 32'hffff_ffff);
        write_reg(CFG_SWEEP_PERIOD, 32'hffff_ffff);
        test_random(30);
        wait_drained();
        write_reg(CFG_IDLE_TIMEOUT, 32'd8);
        write_reg(CFG_SWEEP_PERIOD, 32'd3);
        test_random(70);

        wait_drained();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
